@@ rtl/core/pirf_pkg.sv @@
// package: register codes, operation codes and constants for the privileged register file
`timescale 1ns / 1ps
package pirf_pkg;
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [4:0] REG_SOFTINT = 5'd0;
  localparam logic [4:0] REG_CLR     = 5'd1;
  localparam logic [4:0] REG_SET     = 5'd2;
  localparam logic [4:0] REG_TICKCMP = 5'd3;
  localparam logic [4:0] REG_STICKCMP = 5'd4;
  localparam logic [4:0] REG_PIL     = 5'd5;
  localparam logic [4:0] REG_HVER    = 5'd6;
  localparam logic [4:0] REG_HINTP   = 5'd7;
  localparam logic [4:0] REG_HTBA    = 5'd8;
  localparam logic [4:0] REG_QFIRST  = 5'd9;
  localparam logic [4:0] REG_QLAST   = 5'd16;
  localparam logic [4:0] REG_HSTICKCMP = 5'd17;
  localparam logic [4:0] REG_HPSTATE = 5'd18;
  localparam logic [4:0] REG_HTSTATE = 5'd19;
  localparam logic [4:0] REG_STRAND  = 5'd20;

  localparam int MAX_TRAP_LEVEL_DEF = 6;
  localparam int WINDOW_COUNT_DEF = 8;
  localparam logic [3:0] PIL_HIGH = 4'd14;
  localparam logic [63:0] HP_ID = 64'h800;
  localparam logic [63:0] HTBA_MASK = ~64'h7FFF;
  localparam logic [63:0] CMP_RESET = 64'h8000_0000_0000_0000;

  // command from controller to datapath
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       tick;
    logic [4:0] sel;
    logic [2:0] tl;
  } pirf_cmd_t;

  // status from datapath
  typedef struct packed {
    logic sel_wr_ok;
    logic sel_rd_ok;
  } pirf_sts_t;
endpackage

@@ rtl/core/pirf_dp.sv @@
// datapath: privileged register state, read mux and interrupt lines
`timescale 1ns / 1ps
module pirf_dp #(
  parameter int MAX_TRAP_LEVEL = pirf_pkg::MAX_TRAP_LEVEL_DEF,
  parameter int WINDOW_COUNT = pirf_pkg::WINDOW_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                exec,
  input  pirf_pkg::pirf_cmd_t cmd,
  input  logic [63:0]         wdata,
  output pirf_pkg::pirf_sts_t sts,
  output logic [63:0]         rdata,
  output logic [16:0]         soft_lines,
  output logic [5:0]          flags
);
  localparam logic [63:0] VERSION = (64'h3e << 48) | (64'h23 << 32) | (64'h20 << 24)
    | (64'(MAX_TRAP_LEVEL & 8'hFF) << 8) | 64'((WINDOW_COUNT - 1) & 8'hFF);

  logic [16:0] soft_r, soft_nxt;
  logic [3:0]  pil_r, pil_nxt;
  logic [63:0] tcmp_r, tcmp_nxt, scmp_r, scmp_nxt, hcmp_r, hcmp_nxt;
  logic [62:0] cnt_r, cnt_nxt;
  logic [63:0] hintp_r, hintp_nxt, htba_r, htba_nxt, hps_r, hps_nxt, hts_r, hts_nxt;
  logic [63:0] q_r [8];
  logic        act_r, act_nxt;
  logic        q_sel, strand_bad, sleep;
  logic [2:0]  q_idx;
  logic [63:0] rd_val;
  logic [4:0]  q_off;

  assign q_sel = cmd.sel >= pirf_pkg::REG_QFIRST && cmd.sel <= pirf_pkg::REG_QLAST;
  assign q_off = cmd.sel - pirf_pkg::REG_QFIRST;
  assign q_idx = q_off[2:0];
  assign strand_bad = wdata[2];

  // register selection legality
  always_comb begin
    sts.sel_rd_ok = q_sel;
    unique case (cmd.sel)
      pirf_pkg::REG_SOFTINT, pirf_pkg::REG_TICKCMP, pirf_pkg::REG_STICKCMP,
      pirf_pkg::REG_PIL, pirf_pkg::REG_HVER, pirf_pkg::REG_HINTP, pirf_pkg::REG_HTBA,
      pirf_pkg::REG_HSTICKCMP, pirf_pkg::REG_HPSTATE, pirf_pkg::REG_HTSTATE,
      pirf_pkg::REG_STRAND: sts.sel_rd_ok = 1'b1;
      default: ;
    endcase
    sts.sel_wr_ok = q_sel;
    unique case (cmd.sel)
      pirf_pkg::REG_SOFTINT, pirf_pkg::REG_CLR, pirf_pkg::REG_SET, pirf_pkg::REG_TICKCMP,
      pirf_pkg::REG_STICKCMP, pirf_pkg::REG_PIL, pirf_pkg::REG_HINTP, pirf_pkg::REG_HTBA,
      pirf_pkg::REG_HSTICKCMP, pirf_pkg::REG_HPSTATE, pirf_pkg::REG_HTSTATE:
        sts.sel_wr_ok = 1'b1;
      pirf_pkg::REG_STRAND: sts.sel_wr_ok = !strand_bad;
      default: ;
    endcase
  end

  // next state for writes and ticks
  always_comb begin
    soft_nxt = soft_r; pil_nxt = pil_r; tcmp_nxt = tcmp_r; scmp_nxt = scmp_r;
    hcmp_nxt = hcmp_r; cnt_nxt = cnt_r; hintp_nxt = hintp_r; htba_nxt = htba_r;
    hps_nxt = hps_r; hts_nxt = hts_r; act_nxt = act_r; sleep = 1'b0;
    if (cmd.wr && sts.sel_wr_ok) begin
      unique case (cmd.sel)
        pirf_pkg::REG_SOFTINT:   soft_nxt = wdata[16:0];
        pirf_pkg::REG_CLR:       soft_nxt = soft_r & ~wdata[16:0];
        pirf_pkg::REG_SET:       soft_nxt = soft_r | wdata[16:0];
        pirf_pkg::REG_TICKCMP:   tcmp_nxt = wdata;
        pirf_pkg::REG_STICKCMP:  scmp_nxt = wdata;
        pirf_pkg::REG_PIL:       pil_nxt = wdata[3:0];
        pirf_pkg::REG_HINTP:     hintp_nxt = wdata;
        pirf_pkg::REG_HTBA:      htba_nxt = wdata & pirf_pkg::HTBA_MASK;
        pirf_pkg::REG_HSTICKCMP: hcmp_nxt = wdata;
        pirf_pkg::REG_HPSTATE:   hps_nxt = wdata | pirf_pkg::HP_ID;
        pirf_pkg::REG_HTSTATE:   hts_nxt = wdata;
        pirf_pkg::REG_STRAND: begin
          act_nxt = wdata[0];
          sleep = !wdata[0];
        end
        default: ;
      endcase
    end
    if (cmd.tick) begin
      cnt_nxt = cnt_r + 63'd1;
      if (!scmp_r[63] && scmp_r[62:0] == cnt_nxt) soft_nxt[16] = 1'b1;
      if (!hcmp_r[63] && hcmp_r[62:0] == cnt_nxt) hintp_nxt = 64'd1;
    end
  end

  // read mux
  always_comb begin
    rd_val = 64'd0;
    if (q_sel) rd_val = q_r[q_idx];
    unique case (cmd.sel)
      pirf_pkg::REG_SOFTINT:   rd_val = {47'd0, soft_r};
      pirf_pkg::REG_TICKCMP:   rd_val = tcmp_r;
      pirf_pkg::REG_STICKCMP:  rd_val = scmp_r;
      pirf_pkg::REG_PIL:       rd_val = {60'd0, pil_r};
      pirf_pkg::REG_HVER:      rd_val = VERSION;
      pirf_pkg::REG_HINTP:     rd_val = hintp_r;
      pirf_pkg::REG_HTBA:      rd_val = htba_r;
      pirf_pkg::REG_HSTICKCMP: rd_val = hcmp_r;
      pirf_pkg::REG_HPSTATE:   rd_val = hps_r;
      pirf_pkg::REG_HTSTATE:   rd_val = hts_r;
      pirf_pkg::REG_STRAND:    rd_val = {63'd0, act_r};
      default: ;
    endcase
    if (!(cmd.rd && sts.sel_rd_ok)) rd_val = 64'd0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r <= '0; pil_r <= '0; tcmp_r <= pirf_pkg::CMP_RESET;
      scmp_r <= pirf_pkg::CMP_RESET; hcmp_r <= pirf_pkg::CMP_RESET; cnt_r <= '0;
      hintp_r <= '0; htba_r <= '0; hps_r <= pirf_pkg::HP_ID; hts_r <= '0; act_r <= 1'b1;
      for (int i = 0; i < 8; i++) q_r[i] <= '0;
    end else if (exec) begin
      soft_r <= soft_nxt; pil_r <= pil_nxt; tcmp_r <= tcmp_nxt; scmp_r <= scmp_nxt;
      hcmp_r <= hcmp_nxt; cnt_r <= cnt_nxt; hintp_r <= hintp_nxt; htba_r <= htba_nxt;
      hps_r <= hps_nxt; hts_r <= hts_nxt; act_r <= act_nxt;
      if (cmd.wr && q_sel) q_r[q_idx] <= wdata;
    end
  end

  // result fields from post-item state
  always_comb begin
    soft_lines = '0;
    if (pil_nxt < pirf_pkg::PIL_HIGH) begin
      soft_lines[0] = soft_nxt[0];
      soft_lines[16] = soft_nxt[16];
    end
    for (int b = 1; b < 16; b++)
      soft_lines[b] = soft_nxt[b] && (5'(b) > {1'b0, pil_nxt});
  end

  logic [63:0] q0, q1, q2, q3, q4, q5;
  always_comb begin
    q0 = q_r[0]; q1 = q_r[1]; q2 = q_r[2]; q3 = q_r[3]; q4 = q_r[4]; q5 = q_r[5];
    if (cmd.wr && q_sel) begin
      unique case (q_idx)
        3'd0: q0 = wdata;
        3'd1: q1 = wdata;
        3'd2: q2 = wdata;
        3'd3: q3 = wdata;
        3'd4: q4 = wdata;
        3'd5: q5 = wdata;
        default: ;
      endcase
    end
  end

  // flags: hyper, cpu, dev, res, tlz, sleep
  assign flags = {sleep, hps_nxt[0] && cmd.tl == 3'd0 && !hps_nxt[2],
                  q4 != q5, q2 != q3, q0 != q1, hintp_nxt != 64'd0};
  assign rdata = rd_val;

  a_hp_id: assert property (@(posedge clk) disable iff (!rst_n) hps_r[11])
    else $error("hpstate id bit lost");
  a_htba: assert property (@(posedge clk) disable iff (!rst_n) htba_r[14:0] == 15'd0)
    else $error("htba low bits set");
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    exec && cmd.tick |=> cnt_r == $past(cnt_r) + 63'd1)
    else $error("tick count did not advance");
endmodule

@@ rtl/core/pirf_ctrl.sv @@
// controller: handshake state machine and output register
`timescale 1ns / 1ps
module pirf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          op,
  input  logic [4:0]          sel,
  input  logic [2:0]          tl,
  output logic                exec,
  output pirf_pkg::pirf_cmd_t cmd,
  input  pirf_pkg::pirf_sts_t sts,
  input  logic [63:0]         rdata,
  input  logic [16:0]         soft_lines,
  input  logic [5:0]          flags,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [95:0]         out_tdata
);
  typedef enum logic {ST_RUN, ST_HOLD} state_t;
  state_t state_r;
  logic [95:0] data_r;
  logic        err;

  // a free output slot takes the next item
  assign in_tready = (state_r == ST_RUN) || out_tready;
  assign exec = in_tvalid && in_tready;
  always_comb begin
    cmd.wr = op == pirf_pkg::OP_WRITE;
    cmd.rd = op == pirf_pkg::OP_READ;
    cmd.tick = op == pirf_pkg::OP_TICK;
    cmd.sel = sel;
    cmd.tl = tl;
    err = (cmd.wr && !sts.sel_wr_ok) || (cmd.rd && !sts.sel_rd_ok);
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      unique case (state_r)
        ST_RUN:  if (exec) state_r <= ST_HOLD;
        ST_HOLD: if (out_tready && !exec) state_r <= ST_RUN;
        default: state_r <= ST_RUN;
      endcase
    end
    if (exec)
      data_r <= {8'd0, err, flags, soft_lines, rdata};
  end

  assign out_tvalid = state_r == ST_HOLD;
  assign out_tdata = data_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_tvalid)
    else $error("accepted item produced no result");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:88] == 8'd0)
    else $error("pad bits set");
endmodule

@@ rtl/core/privileged_interrupt_register_file.sv @@
// top level: privileged interrupt register file
`timescale 1ns / 1ps
// Privileged register block: soft interrupts, pil, compare registers,
// hypervisor state and queue pointers, with pending-interrupt lines.
// Input channel in_*: one item per handshake, a register write, a read or a
// system tick (op 3 does nothing). Output channel out_*: exactly one result
// item per input item, in order.
// The result appears in the cycle after the item is accepted, held in
// a single output register.
// Throughput: one item per cycle; in_tready stays high while the output
// register is empty or is being emptied in the same cycle, so the state
// update and result capture happen in the accept cycle.
// When the receiver stalls, the held result stays stable and in_tready
// drops until the result is taken.
// Reset (rst_n low, synchronous): all state registers return to their
// reset values, compare registers disabled, hpstate id bit set, strand
// active, output empty. No clearing pass is needed.
module privileged_interrupt_register_file #(
  parameter int MAX_TRAP_LEVEL = pirf_pkg::MAX_TRAP_LEVEL_DEF,
  parameter int WINDOW_COUNT = pirf_pkg::WINDOW_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // wdata[63:0], trap_level[66:64], zero pad
  input  logic [71:0] in_tdata,
  // op[1:0], reg_sel[6:2]
  input  logic [6:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // rdata[63:0], soft_int_pending[80:64], hyper_int_pending[81],
  // cpu_mondo_pending[82], dev_mondo_pending[83], res_error_pending[84],
  // trap_level_zero_pending[85], sleep_request[86], access_error[87], zero pad
  output logic [95:0] out_tdata
);
  logic                exec;
  pirf_pkg::pirf_cmd_t cmd;
  pirf_pkg::pirf_sts_t sts;
  logic [63:0]         rdata;
  logic [16:0]         soft_lines;
  logic [5:0]          flags;

  pirf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .op(in_tuser[1:0]), .sel(in_tuser[6:2]), .tl(in_tdata[66:64]),
    .exec(exec), .cmd(cmd), .sts(sts), .rdata(rdata), .soft_lines(soft_lines),
    .flags(flags), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  pirf_dp #(.MAX_TRAP_LEVEL(MAX_TRAP_LEVEL), .WINDOW_COUNT(WINDOW_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .exec(exec), .cmd(cmd), .wdata(in_tdata[63:0]),
    .sts(sts), .rdata(rdata), .soft_lines(soft_lines), .flags(flags)
  );
endmodule

@@ verif/tb.sv @@
// testbench for the privileged interrupt register file: directed and random items against a predictor
`timescale 1ns / 1ps
module tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // wdata[63:0], trap_level[66:64], zero pad
  logic [71:0] in_tdata = '0;
  // op[1:0], reg_sel[6:2]
  logic [6:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // rdata[63:0], soft_int_pending[80:64], hyper_int_pending[81],
  // cpu_mondo_pending[82], dev_mondo_pending[83], res_error_pending[84],
  // trap_level_zero_pending[85], sleep_request[86], access_error[87], zero pad
  logic [95:0] out_tdata;

  privileged_interrupt_register_file dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  // predicted register state
  logic [16:0] m_soft;
  logic [3:0]  m_pil;
  logic [63:0] m_tickcmp, m_stickcmp, m_hstickcmp, m_hintp, m_htba;
  logic [63:0] m_hpstate, m_htstate;
  logic [62:0] m_stick;
  logic [63:0] m_queue [8];
  logic        m_active;

  logic [95:0] expected_results [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_access_errs = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  localparam logic [63:0] VERSION_WORD = (64'h3e << 48) | (64'h23 << 32) |
    (64'h20 << 24) | (64'(pirf_pkg::MAX_TRAP_LEVEL_DEF) << 8) |
    64'(pirf_pkg::WINDOW_COUNT_DEF - 1);

  task automatic reset_model();
    m_soft = '0; m_pil = '0;
    m_tickcmp = pirf_pkg::CMP_RESET; m_stickcmp = pirf_pkg::CMP_RESET;
    m_hstickcmp = pirf_pkg::CMP_RESET;
    m_stick = '0; m_hintp = '0; m_htba = '0;
    m_hpstate = pirf_pkg::HP_ID; m_htstate = '0; m_active = 1'b1;
    for (int i = 0; i < 8; i++) m_queue[i] = '0;
  endtask

  // apply one item to the predicted state and build the expected result
  function automatic logic [95:0] predict_regfile(pirf_pkg::op_t op, logic [4:0] sel,
                                                  logic [63:0] wd, logic [2:0] tl);
    logic [63:0] rd;
    logic        err, slp;
    logic [16:0] lines;
    logic [4:0]  q_off;
    rd = '0; err = 1'b0; slp = 1'b0; lines = '0;
    q_off = sel - pirf_pkg::REG_QFIRST;
    if (op == pirf_pkg::OP_WRITE) begin
      if (sel >= pirf_pkg::REG_QFIRST && sel <= pirf_pkg::REG_QLAST)
        m_queue[q_off[2:0]] = wd;
      else case (sel)
        pirf_pkg::REG_SOFTINT:   m_soft = wd[16:0];
        pirf_pkg::REG_CLR:       m_soft = m_soft & ~wd[16:0];
        pirf_pkg::REG_SET:       m_soft = m_soft | wd[16:0];
        pirf_pkg::REG_TICKCMP:   m_tickcmp = wd;
        pirf_pkg::REG_STICKCMP:  m_stickcmp = wd;
        pirf_pkg::REG_PIL:       m_pil = wd[3:0];
        pirf_pkg::REG_HINTP:     m_hintp = wd;
        pirf_pkg::REG_HTBA:      m_htba = wd & pirf_pkg::HTBA_MASK;
        pirf_pkg::REG_HSTICKCMP: m_hstickcmp = wd;
        pirf_pkg::REG_HPSTATE:   m_hpstate = wd | pirf_pkg::HP_ID;
        pirf_pkg::REG_HTSTATE:   m_htstate = wd;
        pirf_pkg::REG_STRAND: begin
          if (wd[2]) err = 1'b1;
          else begin
            m_active = wd[0];
            slp = ~wd[0];
          end
        end
        default:       err = 1'b1;
      endcase
    end else if (op == pirf_pkg::OP_READ) begin
      if (sel >= pirf_pkg::REG_QFIRST && sel <= pirf_pkg::REG_QLAST)
        rd = m_queue[q_off[2:0]];
      else case (sel)
        pirf_pkg::REG_SOFTINT:   rd = 64'(m_soft);
        pirf_pkg::REG_TICKCMP:   rd = m_tickcmp;
        pirf_pkg::REG_STICKCMP:  rd = m_stickcmp;
        pirf_pkg::REG_PIL:       rd = 64'(m_pil);
        pirf_pkg::REG_HVER:      rd = VERSION_WORD;
        pirf_pkg::REG_HINTP:     rd = m_hintp;
        pirf_pkg::REG_HTBA:      rd = m_htba;
        pirf_pkg::REG_HSTICKCMP: rd = m_hstickcmp;
        pirf_pkg::REG_HPSTATE:   rd = m_hpstate;
        pirf_pkg::REG_HTSTATE:   rd = m_htstate;
        pirf_pkg::REG_STRAND:    rd = 64'(m_active);
        default:       err = 1'b1;
      endcase
    end else if (op == pirf_pkg::OP_TICK) begin
      m_stick = m_stick + 63'd1;
      if (!m_stickcmp[63] && m_stickcmp[62:0] == m_stick) m_soft[16] = 1'b1;
      if (!m_hstickcmp[63] && m_hstickcmp[62:0] == m_stick) m_hintp = 64'd1;
    end
    // priority filtering of soft interrupt lines
    if (m_pil < pirf_pkg::PIL_HIGH) begin
      lines[0] = m_soft[0];
      lines[16] = m_soft[16];
    end
    for (int b = 1; b < 16; b++)
      if (m_soft[b] && b > m_pil) lines[b] = 1'b1;
    return {8'd0, err, slp,
            m_hpstate[0] && tl == 3'd0 && !m_hpstate[2],
            m_queue[4] != m_queue[5], m_queue[2] != m_queue[3],
            m_queue[0] != m_queue[1], m_hintp != 64'd0, lines, rd};
  endfunction

  // send one item and queue its expected result
  task automatic send_item(pirf_pkg::op_t op, logic [4:0] sel, logic [63:0] wd,
                           logic [2:0] tl);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, tl, wd};
    in_tuser <= {sel, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(predict_regfile(op, sel, wd, tl));
    n_items++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    logic [95:0] exp_word;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tdata[87]) n_access_errs++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %h", out_tdata);
      end else begin
        exp_word = expected_results.pop_front();
        if (out_tdata !== exp_word) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: rdata exp %h got %h, lines exp %h got %h",
                     exp_word[63:0], out_tdata[63:0], exp_word[95:64], out_tdata[95:64]);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_register_access();
    for (int s = 0; s < 32; s++)
      send_item(pirf_pkg::OP_WRITE, 5'(s), rand64(), 3'($urandom_range(7)));
    for (int s = 0; s < 32; s++)
      send_item(pirf_pkg::OP_READ, 5'(s), rand64(), 3'($urandom_range(7)));
  endtask

  task automatic test_directed();
    // field extremes, strand sleep and speculative refusal, trap level zero
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_SOFTINT, '1, 3'd7);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_PIL, 64'd15, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_PIL, 64'd13, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_PIL, 64'd0, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_CLR, 64'h1_5555, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_SET, 64'h1, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_STRAND, 64'd0, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_STRAND, 64'd5, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_STRAND, 64'd1, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_HPSTATE, 64'd1, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_HPSTATE, 64'd5, 3'd0);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_HPSTATE, 64'd0, 3'd0);
    send_item(pirf_pkg::OP_NOP, pirf_pkg::REG_HVER, '1, 3'd0);
    // compare match on stick and hstick
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_STICKCMP, 64'(m_stick) + 64'd2, 3'd1);
    send_item(pirf_pkg::OP_WRITE, pirf_pkg::REG_HSTICKCMP, 64'(m_stick) + 64'd3, 3'd1);
    repeat (4) send_item(pirf_pkg::OP_TICK, 5'd0, '0, 3'd1);
    wait_drain();
  endtask

  task automatic test_random(int count);
    pirf_pkg::op_t op;
    logic [4:0]    sel;
    logic [63:0]   wd;
    logic [4:0]    q_off;
    for (int i = 0; i < count; i++) begin
      op = pirf_pkg::op_t'($urandom_range(3));
      sel = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(20));
      wd = rand64();
      if ($urandom_range(3) == 0) wd = 64'($urandom_range(20));
      // arm compares close to the counter so they fire
      if (op == pirf_pkg::OP_WRITE &&
          (sel == pirf_pkg::REG_STICKCMP || sel == pirf_pkg::REG_HSTICKCMP) &&
          $urandom_range(1)) wd = 64'(m_stick) + 64'($urandom_range(1, 6));
      q_off = sel - pirf_pkg::REG_QFIRST;
      if (op == pirf_pkg::OP_WRITE && sel >= pirf_pkg::REG_QFIRST &&
          sel <= pirf_pkg::REG_QLAST && $urandom_range(1))
        wd = m_queue[q_off[2:0] ^ 3'd1];
      send_item(op, sel, wd, 3'($urandom_range(7)));
      if (i == count / 2) wait_drain();
    end
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed();
    send_idle_pct = 9; recv_idle_pct = 68;
    test_random(225);
    send_idle_pct = 68; recv_idle_pct = 9;
    test_random(225);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(225);
    wait_drain();
    repeat (10) @(posedge clk);
    $display("covered %0d items, %0d results, %0d refused accesses",
             n_items, n_results, n_access_errs);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
